[rtl/core/swpp_pkg.sv]
// Shared types and constants for the slice window prefetch policy.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps

package swpp_pkg;

   localparam int SLOT_COUNT_DEF = 8;

   localparam int TAG_W      = 16;  // slot tag and request slice, signed
   localparam int SLICE_W    = 15;  // last_slice and new_slice
   localparam int STEP_W     = 9;   // slice_step, signed
   localparam int STATUS_W   = 2;
   localparam int SLOT_IDX_W = 3;   // reported slot index, low bits of the slot number
   localparam int WIN_W      = 18;  // window arithmetic, signed, covers ends before clipping

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 15;

   localparam logic [CSR_IDX_W-1:0] REG_LAST_SLICE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SLICE_STEP = 1'd1;

   localparam logic [STATUS_W-1:0] ST_HIT   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISS  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic load;         // latch the request beat
      logic setup;        // range, hit and raw window ends
      logic lo_inc;       // raise low end by |step|
      logic hi_dec;       // lower high end by |step|
      logic mark_init;    // start the grid marking pass
      logic mark;         // mark slots whose tag equals the current slice
      logic s_next;       // advance the window slice
      logic s_rewind;     // back to the low end
      logic cur_next;     // skip a slot that is still in the window
      logic assign_slot;  // give the current slice to the cursor slot
      logic emit_final;   // push the closing beat
   } swpp_cmd_type;

   typedef struct packed {
      logic out_range;
      logic lo_neg;
      logic hi_over;
      logic s_at_end;
      logic held;
      logic cur_end;
      logic cur_taken;
      logic can_assign;
      logic out_free;
   } swpp_stat_type;

endpackage

[rtl/core/swpp_req_if.sv]
// Request channel: valid/ready handshake carrying the requested slice.
// Depends on swpp_pkg.
`timescale 1ns / 1ps

interface swpp_req_if import swpp_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [TAG_W-1:0]  request_slice;

   modport source (output valid, output request_slice, input ready);
   modport sink   (input valid, input request_slice, output ready);
endinterface

[rtl/core/swpp_rsp_if.sv]
// Result channel: valid/ready handshake carrying one reassignment or status beat.
// Depends on swpp_pkg.
`timescale 1ns / 1ps

interface swpp_rsp_if import swpp_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic                   assign_valid;
   logic [SLOT_IDX_W-1:0]  slot_index;
   logic [SLICE_W-1:0]     new_slice;
   logic                   last;

   modport source (output valid, output status, output assign_valid, output slot_index,
                   output new_slice, output last, input ready);
   modport sink   (input valid, input status, input assign_valid, input slot_index,
                   input new_slice, input last, output ready);
endinterface

[rtl/core/swpp_ctrl.sv]
// Sequencer for the prefetch policy: walks setup, clipping, marking and assignment.
// Depends on swpp_pkg; drives swpp_dp through swpp_cmd_type.
`timescale 1ns / 1ps

module swpp_ctrl import swpp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  swpp_stat_type stat,
   output swpp_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_RANGE  = 3'd1;
   localparam logic [2:0] S_CLIPLO = 3'd2;
   localparam logic [2:0] S_CLIPHI = 3'd3;
   localparam logic [2:0] S_MARK   = 3'd4;
   localparam logic [2:0] S_WALK   = 3'd5;
   localparam logic [2:0] S_SCAN   = 3'd6;
   localparam logic [2:0] S_FINAL  = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_RANGE;
            end
         end
         S_RANGE: begin
            cmd.setup = 1'b1;
            state_in  = stat.out_range ? S_FINAL : S_CLIPLO;
         end
         S_CLIPLO: begin
            if (stat.lo_neg) begin
               cmd.lo_inc = 1'b1;
            end else begin
               state_in = S_CLIPHI;
            end
         end
         S_CLIPHI: begin
            if (stat.hi_over) begin
               cmd.hi_dec = 1'b1;
            end else begin
               cmd.mark_init = 1'b1;
               state_in      = S_MARK;
            end
         end
         S_MARK: begin
            cmd.mark = 1'b1;
            if (stat.s_at_end) begin
               cmd.s_rewind = 1'b1;
               state_in     = S_WALK;
            end else begin
               cmd.s_next = 1'b1;
            end
         end
         S_WALK: begin
            if (stat.held) begin
               if (stat.s_at_end) begin
                  state_in = S_FINAL;
               end else begin
                  cmd.s_next = 1'b1;
               end
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.cur_end) begin
               // no slot left past the cursor: later slices cannot be placed
               state_in = S_FINAL;
            end else if (stat.cur_taken) begin
               cmd.cur_next = 1'b1;
            end else if (stat.can_assign) begin
               cmd.assign_slot = 1'b1;
               if (stat.s_at_end) begin
                  state_in = S_FINAL;
               end else begin
                  cmd.s_next = 1'b1;
                  state_in   = S_WALK;
               end
            end
         end
         S_FINAL: begin
            if (stat.out_free) begin
               cmd.emit_final = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/swpp_dp.sv]
// Datapath for the prefetch policy: config, slot tags, window ends, cursor, result register.
// Depends on swpp_pkg; steered by swpp_ctrl through swpp_cmd_type.
`timescale 1ns / 1ps

module swpp_dp import swpp_pkg::*; #(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic signed [TAG_W-1:0] req_slice,
   input  swpp_cmd_type           cmd,
   output swpp_stat_type          stat,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic                   rsp_assign_valid,
   output logic [SLOT_IDX_W-1:0]  rsp_slot_index,
   output logic [SLICE_W-1:0]     rsp_new_slice,
   output logic                   rsp_last
);

   localparam int IdxW  = $clog2(SLOT_COUNT);
   localparam int CurW  = $clog2(SLOT_COUNT + 1);
   localparam int Half  = SLOT_COUNT / 2 - ((SLOT_COUNT % 2 == 0) ? 1 : 0);
   localparam int Upper = SLOT_COUNT - 1 - Half;

   // configuration
   logic [SLICE_W-1:0]        last_slice_ff, last_slice_in;
   logic signed [STEP_W-1:0]  slice_step_ff, slice_step_in;

   // slot tags
   logic signed [TAG_W-1:0]   tag_ff [SLOT_COUNT];
   logic signed [TAG_W-1:0]   tag_in [SLOT_COUNT];

   // per-request working state
   logic signed [TAG_W-1:0]   t_ff, t_in;
   logic signed [WIN_W-1:0]   a_ff, a_in;
   logic signed [WIN_W-1:0]   lo_ff, lo_in;
   logic signed [WIN_W-1:0]   hi_ff, hi_in;
   logic signed [WIN_W-1:0]   s_ff, s_in;
   logic                      oor_ff, oor_in;
   logic                      hit_ff, hit_in;
   logic [CurW-1:0]           cur_ff, cur_in;
   logic [SLOT_COUNT-1:0]     ingrid_ff, ingrid_in;

   // reassignment held back until it is known whether it closes the request
   logic                      pend_valid_ff, pend_valid_in;
   logic [IdxW-1:0]           pend_slot_ff, pend_slot_in;
   logic [SLICE_W-1:0]        pend_slice_ff, pend_slice_in;

   // result register
   logic                      out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0]       out_status_ff, out_status_in;
   logic                      out_assign_ff, out_assign_in;
   logic [SLOT_IDX_W-1:0]     out_slot_ff, out_slot_in;
   logic [SLICE_W-1:0]        out_slice_ff, out_slice_in;
   logic                      out_last_ff, out_last_in;

   logic signed [STEP_W-1:0]  step_eff;
   logic signed [WIN_W-1:0]   step_w;
   logic signed [WIN_W-1:0]   abs_w;
   logic signed [WIN_W-1:0]   t_w;
   logic signed [WIN_W-1:0]   tmax_w;
   logic signed [WIN_W-1:0]   end_a;
   logic signed [WIN_W-1:0]   end_b;
   logic signed [WIN_W-1:0]   s_nx;
   logic [SLOT_COUNT-1:0]     match_s;
   logic [SLOT_COUNT-1:0]     match_t;
   logic [IdxW-1:0]           cur_idx;
   logic [SLOT_IDX_W+IdxW-1:0] pend_slot_wide;
   logic [STATUS_W-1:0]       req_status;
   logic                      out_free;

   always_comb begin
      step_eff = (slice_step_ff == '0) ? STEP_W'(1) : slice_step_ff;
      step_w   = WIN_W'(step_eff);
      abs_w    = (step_w < 0) ? -step_w : step_w;
      t_w      = WIN_W'(t_ff);
      tmax_w   = $signed(WIN_W'(last_slice_ff));
      end_a    = t_w - step_w * $signed(WIN_W'(Half));
      end_b    = t_w + step_w * $signed(WIN_W'(Upper));
      s_nx     = s_ff + a_ff;
      cur_idx  = cur_ff[IdxW-1:0];
      pend_slot_wide = (SLOT_IDX_W + IdxW)'(pend_slot_ff);
      req_status     = hit_ff ? ST_HIT : ST_MISS;
      out_free       = !out_valid_ff || rsp_ready;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         match_s[i] = (tag_ff[i] == s_ff[TAG_W-1:0]);
         match_t[i] = (tag_ff[i] == t_ff);
      end
   end

   always_comb begin
      stat.out_range  = (t_w < 0) || (t_w > tmax_w);
      stat.lo_neg     = (lo_ff < 0);
      stat.hi_over    = (hi_ff > tmax_w);
      stat.s_at_end   = (s_nx > hi_ff);
      stat.held       = |match_s;
      stat.cur_end    = (cur_ff == CurW'(SLOT_COUNT));
      stat.cur_taken  = !stat.cur_end && ingrid_ff[cur_idx];
      stat.can_assign = !pend_valid_ff || out_free;
      stat.out_free   = out_free;
   end

   always_comb begin
      last_slice_in = last_slice_ff;
      slice_step_in = slice_step_ff;
      tag_in        = tag_ff;
      t_in          = t_ff;
      a_in          = a_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      s_in          = s_ff;
      oor_in        = oor_ff;
      hit_in        = hit_ff;
      cur_in        = cur_ff;
      ingrid_in     = ingrid_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      pend_slice_in = pend_slice_ff;
      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_assign_in = out_assign_ff;
      out_slot_in   = out_slot_ff;
      out_slice_in  = out_slice_ff;
      out_last_in   = out_last_ff;

      if (csr_write_en) begin
         case (csr_index)
            REG_LAST_SLICE: last_slice_in = csr_data[SLICE_W-1:0];
            REG_SLICE_STEP: slice_step_in = $signed(csr_data[STEP_W-1:0]);
            default: ;
         endcase
      end

      if (cmd.load) begin
         t_in = req_slice;
      end
      if (cmd.setup) begin
         a_in   = abs_w;
         lo_in  = (end_a > end_b) ? end_b : end_a;
         hi_in  = (end_a > end_b) ? end_a : end_b;
         oor_in = stat.out_range;
         hit_in = |match_t;
      end
      if (cmd.lo_inc) begin
         lo_in = lo_ff + a_ff;
      end
      if (cmd.hi_dec) begin
         hi_in = hi_ff - a_ff;
      end
      if (cmd.mark_init) begin
         s_in          = lo_ff;
         ingrid_in     = '0;
         cur_in        = '0;
         pend_valid_in = 1'b0;
      end
      if (cmd.mark) begin
         ingrid_in = ingrid_ff | match_s;
      end
      if (cmd.s_next) begin
         s_in = s_nx;
      end
      if (cmd.s_rewind) begin
         s_in = lo_ff;
      end
      if (cmd.cur_next) begin
         cur_in = cur_ff + CurW'(1);
      end

      // drop the beat once taken; a new one below overrides
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end

      if (cmd.assign_slot) begin
         tag_in[cur_idx] = s_ff[TAG_W-1:0];
         cur_in          = cur_ff + CurW'(1);
         if (pend_valid_ff) begin
            out_valid_in  = 1'b1;
            out_status_in = req_status;
            out_assign_in = 1'b1;
            out_slot_in   = pend_slot_wide[SLOT_IDX_W-1:0];
            out_slice_in  = pend_slice_ff;
            out_last_in   = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_slot_in  = cur_idx;
         pend_slice_in = s_ff[SLICE_W-1:0];
      end

      if (cmd.emit_final) begin
         out_valid_in = 1'b1;
         out_last_in  = 1'b1;
         if (oor_ff) begin
            out_status_in = ST_RANGE;
            out_assign_in = 1'b0;
            out_slot_in   = '0;
            out_slice_in  = '0;
         end else if (pend_valid_ff) begin
            out_status_in = req_status;
            out_assign_in = 1'b1;
            out_slot_in   = pend_slot_wide[SLOT_IDX_W-1:0];
            out_slice_in  = pend_slice_ff;
         end else begin
            out_status_in = req_status;
            out_assign_in = 1'b0;
            out_slot_in   = '0;
            out_slice_in  = '0;
         end
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_slice_ff <= '0;
         slice_step_ff <= STEP_W'(1);
         for (int i = 0; i < SLOT_COUNT; i++) begin
            tag_ff[i] <= '1;
         end
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         last_slice_ff <= last_slice_in;
         slice_step_ff <= slice_step_in;
         tag_ff        <= tag_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff          <= t_in;
      a_ff          <= a_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      s_ff          <= s_in;
      oor_ff        <= oor_in;
      hit_ff        <= hit_in;
      cur_ff        <= cur_in;
      ingrid_ff     <= ingrid_in;
      pend_slot_ff  <= pend_slot_in;
      pend_slice_ff <= pend_slice_in;
      out_status_ff <= out_status_in;
      out_assign_ff <= out_assign_in;
      out_slot_ff   <= out_slot_in;
      out_slice_ff  <= out_slice_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_assign_valid = out_assign_ff;
   assign rsp_slot_index   = out_slot_ff;
   assign rsp_new_slice    = out_slice_ff;
   assign rsp_last         = out_last_ff;

endmodule

[rtl/core/slice_window_prefetch_policy.sv]
// Slice window prefetch policy, top level: swpp_ctrl sequencer plus swpp_dp datapath.
// Steps from the accepting edge to the registered closing beat: out of range, setup and then
// the closing beat; in range, setup, clipping of both ends, marking, then the walk.
// Throughput: one request at a time; the next is taken after the closing beat is registered.
// Reset (synchronous, active high): all slots empty, last_slice 0, slice_step 1, no beat out.
// Depends on swpp_pkg, swpp_req_if, swpp_rsp_if, swpp_ctrl and swpp_dp.
`timescale 1ns / 1ps

module slice_window_prefetch_policy import swpp_pkg::*; #(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   swpp_req_if.sink              req_chan,
   swpp_rsp_if.source            rsp_chan,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // Flow of one request:
   //   accept the beat, check range and hit, form the raw window ends,
   //   clip each end one |step| a cycle, mark slots whose tags sit on the
   //   window grid (one slice a cycle), then walk the slices again and hand
   //   each unheld slice to the next slot past the cursor that is off the grid.
   // Each reassignment is held back until the next one or the closing beat, so the final one can carry last.

   swpp_cmd_type  cmd;
   swpp_stat_type stat;
   logic          req_ready;

   swpp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   swpp_dp #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_slice        (req_chan.request_slice),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_status       (rsp_chan.status),
      .rsp_assign_valid (rsp_chan.assign_valid),
      .rsp_slot_index   (rsp_chan.slot_index),
      .rsp_new_slice    (rsp_chan.new_slice),
      .rsp_last         (rsp_chan.last)
   );

   // take a request only while the sequencer is idle
   assign req_chan.ready = req_ready;

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for slice_window_prefetch_policy: request beats in, slot
// reassignment beats out, each compared against an in-bench prediction of the slot tags.
// Depends on swpp_pkg, swpp_req_if, swpp_rsp_if and the block's RTL.

module testbench;
   import swpp_pkg::*;

   localparam int SLOTS        = SLOT_COUNT_DEF;
   // Window reaches HALF_SPAN steps below the request for a positive step, the rest above it.
   localparam int HALF_SPAN    = SLOTS / 2 - ((SLOTS % 2 == 0) ? 1 : 0);
   // Quiet time after the closing beat.
   localparam int DRAIN_CYCLES = 8 * SLOTS;
   localparam int MAX_SHOWN    = 10;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 18;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic                  assign_valid;
      logic [SLOT_IDX_W-1:0] slot_index;
      logic [SLICE_W-1:0]    new_slice;
      logic                  last;
   } slot_beat_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   swpp_req_if req_chan ();
   swpp_rsp_if rsp_chan ();

   slice_window_prefetch_policy #(.SLOT_COUNT(SLOTS)) dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   // Shadow copy of the block: slot tags and both registers.
   logic signed [TAG_W-1:0]  slot_tag [SLOTS];
   logic [SLICE_W-1:0]       shadow_last_slice;
   logic signed [STEP_W-1:0] shadow_step;

   // Beats still owed by the block, oldest first.
   slot_beat_type due_beats [$];

   bit no_stall;      // set to turn off idling on both channels
   int anchor_slice;  // last in-range pick; random requests cluster around it
   int mismatches;
   int requests_sent;
   int beats_seen;
   int hit_beats;
   int miss_beats;
   int range_beats;

   // 12 ns clock.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop: far beyond the slowest legal run (every request at eight beats,
   // full stall budget on both sides), so only a hang gets here.
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Result side: drop ready at random, with a probability of 6 percent, unless idling is off.
   always @(negedge clock) begin
      rsp_chan.ready <= no_stall || ($urandom_range(99) >= 6);
   end

   // Work out the beats one accepted request causes and update the shadow tags.
   function automatic void fill_window(input logic signed [TAG_W-1:0] slice);
      int                  t, tmax, step, span, lo, hi, s, cur, made, tag;
      bit                  held;
      logic [STATUS_W-1:0] status;
      slot_beat_type       beat;
      t    = slice;
      tmax = shadow_last_slice;
      step = shadow_step;
      if (step == 0) begin
         step = 1;
      end
      span = (step < 0) ? -step : step;
      beat = '0;
      // Out of range: one closing beat, tags untouched.
      if (t < 0 || t > tmax) begin
         beat.status = ST_RANGE;
         beat.last   = 1'b1;
         due_beats.push_back(beat);
         return;
      end
      status = ST_MISS;
      foreach (slot_tag[i]) begin
         if (slot_tag[i] == t) status = ST_HIT;
      end
      // Build the window, swap a reversed one, then clip on the grid.
      lo = t - step * HALF_SPAN;
      hi = lo + (SLOTS - 1) * step;
      if (lo > hi) begin
         s  = lo;
         lo = hi;
         hi = s;
      end
      while (lo < 0) lo += span;
      while (hi > tmax) hi -= span;
      cur  = 0;
      made = 0;
      for (s = lo; s <= hi; s += span) begin
         held = 1'b0;
         foreach (slot_tag[i]) begin
            if (slot_tag[i] == s) held = 1'b1;
         end
         if (held) continue;
         // Hand s to the next slot whose tag is outside the window or off its grid.
         while (cur < SLOTS) begin
            tag = slot_tag[cur];
            cur++;
            if (tag < lo || tag > hi || (tag - lo) % span != 0) begin
               slot_tag[cur - 1]  = TAG_W'(s);
               beat.status        = status;
               beat.assign_valid  = 1'b1;
               beat.slot_index    = SLOT_IDX_W'(cur - 1);
               beat.new_slice     = SLICE_W'(s);
               beat.last          = 1'b0;
               due_beats.push_back(beat);
               made++;
               break;
            end
         end
      end
      if (made == 0) begin
         beat        = '0;
         beat.status = status;
         beat.last   = 1'b1;
         due_beats.push_back(beat);
      end else begin
         beat      = due_beats.pop_back();
         beat.last = 1'b1;
         due_beats.push_back(beat);
      end
   endfunction

   // Check every accepted result beat against the oldest owed beat.
   always @(posedge clock) begin
      slot_beat_type seen, owed;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen.status       = rsp_chan.status;
         seen.assign_valid = rsp_chan.assign_valid;
         seen.slot_index   = rsp_chan.slot_index;
         seen.new_slice    = rsp_chan.new_slice;
         seen.last         = rsp_chan.last;
         beats_seen++;
         if (seen.status == ST_HIT) hit_beats++;
         else if (seen.status == ST_MISS) miss_beats++;
         else range_beats++;
         if (due_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN) begin
               $display("%0t: beat with nothing owed: st=%0d av=%0d slot=%0d slice=%0d last=%0d",
                        $realtime, seen.status, seen.assign_valid, seen.slot_index,
                        seen.new_slice, seen.last);
            end
         end else begin
            owed = due_beats.pop_front();
            if (seen !== owed) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN) begin
                  $display("%0t: mismatch: expected st=%0d av=%0d slot=%0d slice=%0d last=%0d",
                           $realtime, owed.status, owed.assign_valid, owed.slot_index,
                           owed.new_slice, owed.last);
                  $display("%0t:           got      st=%0d av=%0d slot=%0d slice=%0d last=%0d",
                           $realtime, seen.status, seen.assign_valid, seen.slot_index,
                           seen.new_slice, seen.last);
               end
            end
         end
      end
   end

   // Send one request beat. Leave valid high on return: the next call either
   // drives the next beat or drops valid at the following falling edge.
   task automatic send_request(input logic signed [TAG_W-1:0] slice);
      @(negedge clock);
      while (!no_stall && $urandom_range(99) < 6) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.request_slice <= slice;
      do @(posedge clock); while (!req_chan.ready);
      fill_window(slice);
      requests_sent++;
   endtask

   // Drop valid, wait for every owed beat, then let the block go quiet.
   task automatic settle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (due_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input int value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_data     <= CSR_DATA_W'(value);
      if (index == REG_LAST_SLICE) shadow_last_slice = SLICE_W'(value);
      else shadow_step = STEP_W'(value);
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Registers change only with the block idle.
   task automatic reconfigure(input int top_slice, input int step);
      settle();
      write_reg(REG_LAST_SLICE, top_slice);
      write_reg(REG_SLICE_STEP, step);
   endtask

   // Mostly in-range requests, either near the previous pick, so windows overlap and hits
   // happen, or anywhere in range; the rest are raw 16-bit noise or just past either end.
   function automatic logic signed [TAG_W-1:0] pick_slice();
      int tmax, step, pick, roll;
      tmax = shadow_last_slice;
      step = shadow_step;
      if (step == 0) begin
         step = 1;
      end
      roll = $urandom_range(99);
      if (roll < 10) begin
         return TAG_W'($urandom);
      end else if (roll < 15) begin
         return (roll < 13) ? TAG_W'(tmax + 1 + $urandom_range(3))
                            : TAG_W'(-1 - int'($urandom_range(3)));
      end else if (roll < 65) begin
         pick = anchor_slice + (int'($urandom_range(6)) - 3) * step;
         if (pick < 0) pick = 0;
         if (pick > tmax) pick = tmax;
      end else begin
         pick = $urandom_range(tmax);
      end
      anchor_slice = pick;
      return TAG_W'(pick);
   endfunction

   // Reset values: last_slice 0, step 1, so only slice 0 is in range.
   task automatic test_reset_state();
      send_request(16'sd0);       // miss, slot 0 takes slice 0
      send_request(16'sd0);       // hit, nothing to reassign
      send_request(16'sd1);       // just above last_slice
      send_request(-16'sd1);
      send_request(-16'sd32768);  // most negative request
      send_request(16'sd32767);   // largest positive request
   endtask

   // Widest slice range with steps of 255 and -255, forward and reversed.
   task automatic test_full_span();
      reconfigure(32767, 255);
      send_request(16'sd32767);   // window clipped at the top
      send_request(16'sd0);       // window clipped at the bottom
      send_request(16'sd16384);
      send_request(16'sd32767);   // repeat of the first request, now a miss
      reconfigure(32767, -255);
      send_request(16'sd1000);    // negative step, window swapped
      send_request(16'sd21845);
   endtask

   // Zero step behaves as one; then a step of minus one.
   task automatic test_zero_step();
      reconfigure(200, 0);
      send_request(16'sd100);
      send_request(16'sd101);
      send_request(16'sd97);
      reconfigure(200, -1);
      send_request(16'sd50);
      send_request(16'sd53);
   endtask

   // Coarse grid over a short range: tags left off the grid get reclaimed.
   task automatic test_off_grid();
      reconfigure(5, 2);
      send_request(16'sd3);
      send_request(16'sd4);
      send_request(16'sd0);
   endtask

   // Random phases, each with its own register settings. One phase runs with no
   // idling at all; another holds the sender until all owed beats are in.
   task automatic test_random_phases();
      int top_slice, step, roll;
      for (int phase = 0; phase < PHASES; phase++) begin
         roll = $urandom_range(4);
         if (roll == 0) top_slice = 0;
         else if (roll == 1) top_slice = 32767;
         else top_slice = $urandom_range(60, 2);
         roll = $urandom_range(9);
         if (roll < 7) step = int'($urandom_range(8)) - 4;
         else if (roll == 7) step = 255;
         else if (roll == 8) step = -255;
         else step = int'($urandom_range(510)) - 255;
         reconfigure(top_slice, step);
         anchor_slice = $urandom_range(top_slice);
         no_stall = (phase == 4);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 3 && n == PHASE_ITEMS / 2) begin
               settle();
            end
            send_request(pick_slice());
         end
      end
      no_stall = 1'b0;
   endtask

   initial begin
      reset             = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.request_slice = '0;
      rsp_chan.ready    = 1'b0;
      csr_write_en      = 1'b0;
      csr_index         = '0;
      csr_data          = '0;
      no_stall          = 1'b0;
      anchor_slice      = 0;
      mismatches        = 0;
      requests_sent     = 0;
      beats_seen        = 0;
      hit_beats         = 0;
      miss_beats        = 0;
      range_beats       = 0;
      shadow_last_slice = '0;
      shadow_step       = 9'sd1;
      foreach (slot_tag[i]) slot_tag[i] = -16'sd1;

      // Hold reset, then release it on a falling edge.
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_full_span();
      test_zero_step();
      test_off_grid();
      test_random_phases();
      settle();

      $display("Sent %0d requests over %0d register settings; checked %0d result beats",
               requests_sent, PHASES + 6, beats_seen);
      $display("Beat mix: %0d hit, %0d miss, %0d out of range; %0d mismatches",
               hit_beats, miss_beats, range_beats, mismatches);
      if (mismatches == 0 && due_beats.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
